@@ hw/rtl/cna_pkg.sv @@
// shared types, constants and the output clipping function of the complex alu
package cna_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DW            = 32;          // operand and result part width
    localparam int PW            = 64;          // product width
    localparam int VW            = 67;          // signed width of sums of products
    localparam int DIV_STEPS     = 33;          // quotient bits, one per cell
    localparam int QW            = DIV_STEPS + 1;

    // magnitudes at or above this value always clip
    localparam logic [QW-1:0] QCLAMP = {1'b1, {(QW-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_DIVR = 3'd4,
        OP_CONJ = 3'd5,
        OP_MOD  = 3'd6,
        OP_NONE = 3'd7
    } t_op;

    typedef struct packed {
        logic [2:0]            operation;
        logic signed [DW-1:0]  a_re;
        logic signed [DW-1:0]  a_im;
        logic signed [DW-1:0]  b_re;
        logic signed [DW-1:0]  b_im;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0]  res_re;
        logic signed [DW-1:0]  res_im;
        logic                  divide_fault;
        logic                  saturated;
    } t_out;

    // one item as it travels down the divider chain
    typedef struct packed {
        logic                  valid;
        logic                  bypass;      // result already final, cells leave it alone
        logic                  fault;
        logic                  neg_re;
        logic                  neg_im;
        logic                  ovf_re;
        logic                  ovf_im;
        logic [PW-1:0]         den;
        logic [PW-1:0]         rem_re;
        logic [PW-1:0]         rem_im;
        logic [DIV_STEPS-1:0]  low_re;
        logic [DIV_STEPS-1:0]  low_im;
        logic [QW-1:0]         q_re;
        logic [QW-1:0]         q_im;
    } t_cell;

    typedef struct packed {
        logic [DW-1:0] bits;
        logic          sat;
    } t_clip;

    // sign and magnitude to signed 32 bits with clipping
    function automatic t_clip clip_part(input logic neg, input logic ovf,
                                        input logic [QW-1:0] q);
        t_clip         r;
        logic [QW-1:0] mag;
        mag    = ovf ? QCLAMP : q;
        r.bits = '0;
        r.sat  = 1'b0;
        if (mag == '0) begin
            r.bits = '0;
        end else if (neg) begin
            if (mag > QW'(34'h0_8000_0000)) begin
                r.sat  = 1'b1;
                r.bits = 32'h8000_0000;
            end else begin
                r.bits = DW'(~mag + QW'(1));
            end
        end else begin
            if (mag > QW'(34'h0_7FFF_FFFF)) begin
                r.sat  = 1'b1;
                r.bits = 32'h7FFF_FFFF;
            end else begin
                r.bits = mag[DW-1:0];
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/cna_front.sv @@
// front end: products, sums and setup of the divider chain
module cna_front import cna_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_in   i_data,
    output t_cell o_cell
);

    localparam int BW = PW + FRAC_BITS;

    // stage 1: products
    logic                 r1_valid;
    t_op                  r1_op;
    logic signed [DW-1:0] r1_a_re, r1_a_im, r1_b_re, r1_b_im;
    logic signed [PW-1:0] r1_m0, r1_m1, r1_m2, r1_m3, r1_m4, r1_m5;
    logic signed [PW-1:0] n_m0, n_m1;
    t_op                  in_op;

    assign in_op = t_op'(i_data.operation);

    always_comb begin
        if (in_op == OP_MOD) begin
            n_m0 = i_data.a_re * i_data.a_re;
            n_m1 = i_data.a_im * i_data.a_im;
        end else begin
            n_m0 = i_data.a_re * i_data.b_re;
            n_m1 = i_data.a_im * i_data.b_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_op   <= in_op;
            r1_a_re <= i_data.a_re;
            r1_a_im <= i_data.a_im;
            r1_b_re <= i_data.b_re;
            r1_b_im <= i_data.b_im;
            r1_m0   <= n_m0;
            r1_m1   <= n_m1;
            r1_m2   <= i_data.a_re * i_data.b_im;
            r1_m3   <= i_data.a_im * i_data.b_re;
            r1_m4   <= i_data.b_re * i_data.b_re;
            r1_m5   <= i_data.b_im * i_data.b_im;
        end
    end

    // stage 2: sums
    logic                 r2_valid, r2_div, r2_scl, r2_flip;
    logic signed [VW-1:0] r2_re, r2_im;
    logic [PW-1:0]        r2_den;
    logic signed [VW-1:0] n_re, n_im;
    logic [PW-1:0]        n_den;
    logic                 n_div, n_scl, n_flip;

    always_comb begin
        n_re   = '0;
        n_im   = '0;
        n_den  = '0;
        n_div  = 1'b0;
        n_scl  = 1'b0;
        n_flip = 1'b0;
        unique case (r1_op)
            OP_ADD: begin
                n_re = VW'(r1_a_re) + VW'(r1_b_re);
                n_im = VW'(r1_a_im) + VW'(r1_b_im);
            end
            OP_SUB: begin
                n_re = VW'(r1_a_re) - VW'(r1_b_re);
                n_im = VW'(r1_a_im) - VW'(r1_b_im);
            end
            OP_MUL: begin
                n_re  = VW'(r1_m0) - VW'(r1_m1);
                n_im  = VW'(r1_m2) + VW'(r1_m3);
                n_scl = 1'b1;
            end
            OP_DIV: begin
                n_re  = VW'(r1_m0) + VW'(r1_m1);
                n_im  = VW'(r1_m3) - VW'(r1_m2);
                n_den = $unsigned(r1_m4) + $unsigned(r1_m5);
                n_div = 1'b1;
            end
            OP_DIVR: begin
                n_re   = VW'(r1_a_re);
                n_im   = VW'(r1_a_im);
                n_den  = r1_b_re[DW-1] ? PW'(-VW'(r1_b_re)) : PW'(VW'(r1_b_re));
                n_div  = 1'b1;
                n_flip = r1_b_re[DW-1];
            end
            OP_CONJ: begin
                n_re = VW'(r1_a_re);
                n_im = -VW'(r1_a_im);
            end
            OP_MOD: begin
                n_re  = VW'(r1_m0) + VW'(r1_m1);
                n_scl = 1'b1;
            end
            default: begin
                n_re = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_re   <= n_re;
            r2_im   <= n_im;
            r2_den  <= n_den;
            r2_div  <= n_div;
            r2_scl  <= n_scl;
            r2_flip <= n_flip;
        end
    end

    // stage 3: sign and magnitude, scaling, divider setup
    logic          neg_re, neg_im, fault;
    logic [VW-1:0] mag_re, mag_im;
    logic [BW-1:0] big_re, big_im, top_re, top_im;
    t_cell         n_cell, r_cell;

    always_comb begin
        neg_re = r2_re[VW-1];
        neg_im = r2_im[VW-1];
        mag_re = neg_re ? $unsigned(-r2_re) : $unsigned(r2_re);
        mag_im = neg_im ? $unsigned(-r2_im) : $unsigned(r2_im);
        if (r2_scl) begin
            mag_re = mag_re >> FRAC_BITS;
            mag_im = mag_im >> FRAC_BITS;
        end
        fault  = r2_div && (r2_den == '0);
        big_re = BW'(mag_re[PW-1:0]) << FRAC_BITS;
        big_im = BW'(mag_im[PW-1:0]) << FRAC_BITS;
        top_re = big_re >> DIV_STEPS;
        top_im = big_im >> DIV_STEPS;

        n_cell        = '0;
        n_cell.valid  = r2_valid;
        n_cell.fault  = fault;
        n_cell.den    = r2_den;
        if (fault) begin
            n_cell.bypass = 1'b1;
        end else if (r2_div) begin
            n_cell.bypass = 1'b0;
            n_cell.neg_re = neg_re ^ r2_flip;
            n_cell.neg_im = neg_im ^ r2_flip;
            n_cell.ovf_re = top_re >= BW'(r2_den);
            n_cell.ovf_im = top_im >= BW'(r2_den);
            n_cell.rem_re = top_re[PW-1:0];
            n_cell.rem_im = top_im[PW-1:0];
            n_cell.low_re = big_re[DIV_STEPS-1:0];
            n_cell.low_im = big_im[DIV_STEPS-1:0];
        end else begin
            n_cell.bypass = 1'b1;
            n_cell.neg_re = neg_re;
            n_cell.neg_im = neg_im;
            n_cell.q_re   = (mag_re > VW'(QCLAMP)) ? QCLAMP : mag_re[QW-1:0];
            n_cell.q_im   = (mag_im > VW'(QCLAMP)) ? QCLAMP : mag_im[QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.bypass <= n_cell.bypass;
            r_cell.fault  <= n_cell.fault;
            r_cell.neg_re <= n_cell.neg_re;
            r_cell.neg_im <= n_cell.neg_im;
            r_cell.ovf_re <= n_cell.ovf_re;
            r_cell.ovf_im <= n_cell.ovf_im;
            r_cell.den    <= n_cell.den;
            r_cell.rem_re <= n_cell.rem_re;
            r_cell.rem_im <= n_cell.rem_im;
            r_cell.low_re <= n_cell.low_re;
            r_cell.low_im <= n_cell.low_im;
            r_cell.q_re   <= n_cell.q_re;
            r_cell.q_im   <= n_cell.q_im;
        end
    end

    assign o_cell = r_cell;

endmodule

@@ hw/rtl/cna_cell.sv @@
// one restoring division cell: a quotient bit for both lanes
module cna_cell import cna_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);

    logic [PW:0] trial_re, trial_im;
    logic        ge_re, ge_im;
    t_cell       n_cell, r_cell;

    always_comb begin
        trial_re = {i_cell.rem_re, i_cell.low_re[DIV_STEPS-1]};
        trial_im = {i_cell.rem_im, i_cell.low_im[DIV_STEPS-1]};
        ge_re    = trial_re >= {1'b0, i_cell.den};
        ge_im    = trial_im >= {1'b0, i_cell.den};
        n_cell   = i_cell;
        if (!i_cell.bypass) begin
            n_cell.rem_re = ge_re ? PW'(trial_re - {1'b0, i_cell.den}) : trial_re[PW-1:0];
            n_cell.rem_im = ge_im ? PW'(trial_im - {1'b0, i_cell.den}) : trial_im[PW-1:0];
            n_cell.low_re = i_cell.low_re << 1;
            n_cell.low_im = i_cell.low_im << 1;
            n_cell.q_re   = {i_cell.q_re[QW-2:0], ge_re};
            n_cell.q_im   = {i_cell.q_im[QW-2:0], ge_im};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.bypass <= n_cell.bypass;
            r_cell.fault  <= n_cell.fault;
            r_cell.neg_re <= n_cell.neg_re;
            r_cell.neg_im <= n_cell.neg_im;
            r_cell.ovf_re <= n_cell.ovf_re;
            r_cell.ovf_im <= n_cell.ovf_im;
            r_cell.den    <= n_cell.den;
            r_cell.rem_re <= n_cell.rem_re;
            r_cell.rem_im <= n_cell.rem_im;
            r_cell.low_re <= n_cell.low_re;
            r_cell.low_im <= n_cell.low_im;
            r_cell.q_re   <= n_cell.q_re;
            r_cell.q_im   <= n_cell.q_im;
        end
    end

    assign o_cell = r_cell;

endmodule

@@ hw/rtl/complex_number_alu_unit.sv @@
// complex alu top level: front end, chain of division cells, output clipping
// stages: 3 front stages, 33 division cells and 1 output register
// throughput: one transfer per cycle; the chain moves as a whole and holds
// only while a result sits in the output register and is not taken
// reset: synchronous active low, clears every stage valid bit, no result shown
module complex_number_alu_unit import cna_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // pipeline advance: output slot empty or being taken
    logic  en;
    t_cell chain [0:DIV_STEPS];

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // products, sums, scaling and divider setup
    cna_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_cell  (chain[0])
    );

    // one quotient bit per cell, msb first; bypass items ride along untouched
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        cna_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cell  (chain[k]),
            .o_cell  (chain[k+1])
        );
    end

    // final clipping to signed 32 bits
    t_clip clip_re, clip_im;
    t_out  n_out, r_out;
    logic  r_out_valid;
    t_cell last;

    assign last = chain[DIV_STEPS];

    always_comb begin
        clip_re            = clip_part(last.neg_re, last.ovf_re && !last.bypass, last.q_re);
        clip_im            = clip_part(last.neg_im, last.ovf_im && !last.bypass, last.q_im);
        n_out.res_re       = clip_re.bits;
        n_out.res_im       = clip_im.bits;
        n_out.divide_fault = last.fault;
        n_out.saturated    = clip_re.sat || clip_im.sat;
        // zero divisor forces a clean zero result
        if (last.fault) begin
            n_out.res_re    = '0;
            n_out.res_im    = '0;
            n_out.saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a faulted division never reports clipping and shows zero
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.divide_fault |->
            o_out_data.res_re == '0 && o_out_data.res_im == '0 && !o_out_data.saturated)
        else $error("faulted result not zero");

    // clipping only ever lands on a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |->
            o_out_data.res_re == 32'sh7FFF_FFFF || o_out_data.res_re == -32'sh8000_0000 ||
            o_out_data.res_im == 32'sh7FFF_FFFF || o_out_data.res_im == -32'sh8000_0000)
        else $error("saturated without rail value");

    // a result held back stalls the whole chain
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(last) && o_out_valid)
        else $error("chain moved during stall");

    // nothing emerges right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule
